// ===== src/pvm_pkg.sv =====
// Package for the PCM voice mixer: opcodes, register indexes, sizes and the
// structures passed between the front, the command queue and the back end.
// No dependencies.
package pvm_pkg;

	localparam int STORE_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic [15:0] VOLUME_ONE = 16'h8000;

	typedef enum logic [2:0] {
		OP_WRITE   = 3'd0,
		OP_MIX     = 3'd1,
		OP_PLAY    = 3'd2,
		OP_PAUSE   = 3'd3,
		OP_RESTART = 3'd4,
		OP_STOP    = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		CFG_CHANNELS = 2'd0,
		CFG_TOTAL    = 2'd1,
		CFG_LOOP     = 2'd2,
		CFG_VOLUME   = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_MIX   = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0]  channels;
		logic [16:0] total;
		logic        loop_en;
		logic [15:0] volume;
	} cfg_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic               stereo;
		logic               act;
		logic               playing;
		logic [ADDR_W-1:0]  addr_a;
		logic [ADDR_W-1:0]  addr_b;
		logic [15:0]        value;
		logic signed [15:0] mix_l;
		logic signed [15:0] mix_r;
		logic [15:0]        position;
	} cmd_t;

	typedef struct packed {
		logic               act;
		logic               side;
		logic               playing;
		logic signed [15:0] mix_in;
		logic [15:0]        position;
	} tag_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               playing;
		logic [15:0]        position;
	} res_t;

endpackage

// ===== src/pvm_front.sv =====
// Front end of the PCM voice mixer: accepts beats, keeps the play position and
// playing flag, and turns write and mix beats into queue commands.
// Depends on pvm_pkg.
module pvm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [2:0]          opcode,
	input  logic [15:0]         write_address,
	input  logic signed [15:0]  write_value,
	input  logic signed [15:0]  mix_left_in,
	input  logic signed [15:0]  mix_right_in,
	input  pvm_pkg::cfg_t       cfg,
	output logic                q_push,
	output pvm_pkg::cmd_t       q_data,
	input  logic                q_full
);

	logic [15:0]        pos_q;
	logic               playing_q;
	logic               accept;
	pvm_pkg::op_t       op;
	logic               stereo;
	logic [16:0]        step;
	logic [16:0]        sum17;
	logic [16:0]        wrap17;
	logic [15:0]        next_pos;
	logic signed [17:0] limit;
	logic               at_end;
	logic [15:0]        new_pos;
	logic               new_play;
	logic [15:0]        idx_cur;
	logic [15:0]        idx_next;

	assign op     = pvm_pkg::op_t'(opcode);
	assign accept = push && !q_full;
	assign full   = q_full;

	always_comb begin
		stereo   = cfg.channels[1];
		step     = stereo ? 17'd2 : 17'd1;
		sum17    = {1'b0, pos_q} + step;
		wrap17   = (sum17 >= cfg.total) ? (sum17 - cfg.total) : sum17;
		next_pos = wrap17[15:0];
		limit    = $signed({1'b0, cfg.total}) - $signed({1'b0, step}) - 18'sd1;
		at_end   = $signed({2'b00, next_pos}) >= limit;
		new_pos  = at_end ? 16'd0 : next_pos;
		new_play = at_end ? cfg.loop_en : 1'b1;
		idx_cur  = stereo ? {pos_q[15:1], 1'b0} : pos_q;
		idx_next = stereo ? {next_pos[15:1], 1'b0} : next_pos;
	end

	always_comb begin
		q_data          = '0;
		q_data.stereo   = stereo;
		q_data.mix_l    = mix_left_in;
		q_data.mix_r    = mix_right_in;
		q_data.value    = write_value;
		q_data.act      = playing_q;
		q_data.playing  = playing_q ? new_play : 1'b0;
		q_data.position = playing_q ? new_pos : pos_q;
		if (op == pvm_pkg::OP_WRITE) begin
			q_data.kind   = pvm_pkg::CMD_WRITE;
			q_data.addr_a = pvm_pkg::ADDR_W'(write_address);
			q_data.addr_b = pvm_pkg::ADDR_W'(write_address);
		end else begin
			q_data.kind   = pvm_pkg::CMD_MIX;
			q_data.addr_a = pvm_pkg::ADDR_W'(idx_cur);
			q_data.addr_b = pvm_pkg::ADDR_W'(idx_next);
		end
		q_push = accept && (op == pvm_pkg::OP_WRITE || op == pvm_pkg::OP_MIX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			playing_q <= 1'b0;
		end else if (accept) begin
			unique case (op)
				pvm_pkg::OP_PLAY: begin
					playing_q <= 1'b1;
				end
				pvm_pkg::OP_PAUSE: begin
					playing_q <= 1'b0;
				end
				pvm_pkg::OP_RESTART: begin
					playing_q <= 1'b1;
					pos_q     <= '0;
				end
				pvm_pkg::OP_STOP: begin
					playing_q <= 1'b0;
					pos_q     <= '0;
				end
				pvm_pkg::OP_MIX: begin
					if (playing_q) begin
						pos_q     <= new_pos;
						playing_q <= new_play;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== src/pvm_cmd_queue.sv =====
// Command queue between the front end and the back end of the voice mixer.
// Depends on pvm_pkg.
module pvm_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pvm_pkg::cmd_t data_in,
	output logic          full,
	input  logic          pop,
	output pvm_pkg::cmd_t data_out,
	output logic          empty
);

	pvm_pkg::cmd_t                   slot_q [pvm_pkg::CMD_DEPTH];
	logic [pvm_pkg::CMD_PTR_W-1:0]   wp_q;
	logic [pvm_pkg::CMD_PTR_W-1:0]   rp_q;
	logic [pvm_pkg::CMD_CNT_W-1:0]   cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign full     = cnt_q == pvm_pkg::CMD_CNT_W'(pvm_pkg::CMD_DEPTH);
	assign empty    = cnt_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign data_out = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/pvm_back.sv =====
// Back end of the voice mixer: sample store, two-phase frame reads, average,
// volume scaling, mix add and the result queue.
// Depends on pvm_pkg.
module pvm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  pvm_pkg::cmd_t         q_head,
	output logic                  q_pop,
	input  logic [15:0]           volume,
	output logic                  empty,
	input  logic                  pop,
	output pvm_pkg::res_t         res
);

	logic [15:0]                   store [pvm_pkg::STORE_DEPTH];
	logic signed [15:0]            rd_a_q;
	logic signed [15:0]            rd_b_q;
	logic                          ph_q;
	logic [pvm_pkg::OUT_CNT_W-1:0] inflight_q;
	logic [pvm_pkg::OUT_CNT_W-1:0] ocnt_q;
	logic [pvm_pkg::OUT_PTR_W-1:0] owp_q;
	logic [pvm_pkg::OUT_PTR_W-1:0] orp_q;
	pvm_pkg::res_t                 ofifo_q [pvm_pkg::OUT_DEPTH];
	logic signed [15:0]            left_q;

	logic                          v_s1, v_s2, v_s3;
	pvm_pkg::tag_t                 tag_s1, tag_s2, tag_s3;
	logic signed [15:0]            avg_s2;
	logic signed [32:0]            prod_s3;

	logic                          credit_ok;
	logic                          is_write;
	logic                          issue0;
	logic                          issue1;
	logic [pvm_pkg::ADDR_W-1:0]    ra;
	logic [pvm_pkg::ADDR_W-1:0]    rb;
	logic signed [16:0]            sum17;
	logic signed [16:0]            adj17;
	logic signed [16:0]            half17;
	logic signed [16:0]            vol_s;
	logic signed [32:0]            rnd;
	logic signed [32:0]            shifted;
	logic signed [15:0]            contrib;
	logic signed [15:0]            mixed;
	logic                          opush;
	logic                          opop;
	pvm_pkg::res_t                 onew;

	always_comb begin
		credit_ok = ({1'b0, ocnt_q} + {1'b0, inflight_q})
			< (pvm_pkg::OUT_CNT_W + 1)'(pvm_pkg::OUT_DEPTH);
		is_write  = !q_empty && q_head.kind == pvm_pkg::CMD_WRITE;
		issue0    = !q_empty && q_head.kind == pvm_pkg::CMD_MIX && !ph_q && credit_ok;
		issue1    = !q_empty && q_head.kind == pvm_pkg::CMD_MIX && ph_q;
		q_pop     = is_write || issue1;
		ra = ph_q ? (q_head.addr_a | pvm_pkg::ADDR_W'(q_head.stereo)) : q_head.addr_a;
		rb = ph_q ? (q_head.addr_b | pvm_pkg::ADDR_W'(q_head.stereo)) : q_head.addr_b;
	end

	always_ff @(posedge clk) begin
		if (is_write) begin
			store[q_head.addr_a] <= q_head.value;
		end
		rd_a_q <= store[ra];
	end

	always_ff @(posedge clk) begin
		rd_b_q <= store[rb];
	end

	always_comb begin
		sum17  = 17'(rd_a_q) + 17'(rd_b_q);
		adj17  = sum17 + $signed({16'b0, sum17[16]});
		half17 = adj17 >>> 1;
		vol_s  = (volume > pvm_pkg::VOLUME_ONE) ? $signed({1'b0, pvm_pkg::VOLUME_ONE})
			: $signed({1'b0, volume});
		rnd     = prod_s3 + (prod_s3[32] ? 33'sd32767 : 33'sd0);
		shifted = rnd >>> 15;
		contrib = shifted[15:0];
		mixed   = tag_s3.mix_in + (tag_s3.act ? contrib : 16'sd0);
		opush   = v_s3 && tag_s3.side;
		opop    = pop && !empty;
		onew.left     = left_q;
		onew.right    = mixed;
		onew.playing  = tag_s3.playing;
		onew.position = tag_s3.position;
	end

	always_ff @(posedge clk) begin
		tag_s1.act      <= q_head.act;
		tag_s1.side     <= ph_q;
		tag_s1.playing  <= q_head.playing;
		tag_s1.mix_in   <= ph_q ? q_head.mix_r : q_head.mix_l;
		tag_s1.position <= q_head.position;
		tag_s2          <= tag_s1;
		avg_s2          <= half17[15:0];
		tag_s3          <= tag_s2;
		prod_s3         <= avg_s2 * vol_s;
		if (v_s3 && !tag_s3.side) begin
			left_q <= mixed;
		end
		if (opush) begin
			ofifo_q[owp_q] <= onew;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q       <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			inflight_q <= '0;
			ocnt_q     <= '0;
			owp_q      <= '0;
			orp_q      <= '0;
		end else begin
			if (issue0) begin
				ph_q <= 1'b1;
			end else if (issue1) begin
				ph_q <= 1'b0;
			end
			v_s1 <= issue0 || issue1;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (issue0 && !opush) begin
				inflight_q <= inflight_q + 1'b1;
			end else if (opush && !issue0) begin
				inflight_q <= inflight_q - 1'b1;
			end
			if (opush) begin
				owp_q <= owp_q + 1'b1;
			end
			if (opop) begin
				orp_q <= orp_q + 1'b1;
			end
			if (opush && !opop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (opop && !opush) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

	assign empty = ocnt_q == '0;
	assign res   = ofifo_q[orp_q];

endmodule

// ===== src/pcm_voice_mixer.sv =====
// Result path: a mix beat passes the command queue, the store read registers, the average
// and product registers and the result queue; write and control beats produce no result.
// Throughput: one input beat per cycle into a four-entry command queue while it is not
// full; the back end retires a write as soon as it heads the queue and reads a mix in two
// phases, the first waiting for room in the result queue, as the two store read ports serve four reads per frame.
// Reset: arst_n clears position, playing flag, queues, config and valid bits; store and data registers are not cleared.
module pcm_voice_mixer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         opcode,
	input  logic [15:0]        write_address,
	input  logic signed [15:0] write_value,
	input  logic signed [15:0] mix_left_in,
	input  logic signed [15:0] mix_right_in,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] mix_left_out,
	output logic signed [15:0] mix_right_out,
	output logic               voice_playing,
	output logic [15:0]        frame_position,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [16:0]        cfg_data
);

	pvm_pkg::cfg_t cfg_q;
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;
	pvm_pkg::cmd_t q_in;
	pvm_pkg::cmd_t q_head;
	pvm_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channels <= 2'd2;
			cfg_q.total    <= '0;
			cfg_q.loop_en  <= 1'b0;
			cfg_q.volume   <= pvm_pkg::VOLUME_ONE;
		end else if (cfg_we) begin
			unique case (pvm_pkg::cfg_idx_t'(cfg_index))
				pvm_pkg::CFG_CHANNELS: cfg_q.channels <= cfg_data[1:0];
				pvm_pkg::CFG_TOTAL:    cfg_q.total    <= cfg_data;
				pvm_pkg::CFG_LOOP:     cfg_q.loop_en  <= cfg_data[0];
				pvm_pkg::CFG_VOLUME:   cfg_q.volume   <= cfg_data[15:0];
			endcase
		end
	end

	pvm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.opcode        (opcode),
		.write_address (write_address),
		.write_value   (write_value),
		.mix_left_in   (mix_left_in),
		.mix_right_in  (mix_right_in),
		.cfg           (cfg_q),
		.q_push        (q_push),
		.q_data        (q_in),
		.q_full        (q_full)
	);

	pvm_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.data_in  (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.data_out (q_head),
		.empty    (q_empty)
	);

	pvm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.volume  (cfg_q.volume),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign mix_left_out   = res.left;
	assign mix_right_out  = res.right;
	assign voice_playing  = res.playing;
	assign frame_position = res.position;

endmodule

// ===== src/pvm_checker.sv =====
// Port-level assertions for the PCM voice mixer, attached by a bind statement.
// Depends on pvm_pkg and pcm_voice_mixer.
module pvm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic [2:0]         opcode,
	input logic               pop,
	input logic               empty,
	input logic signed [15:0] mix_left_out,
	input logic signed [15:0] mix_right_out,
	input logic               voice_playing,
	input logic [15:0]        frame_position
);

	localparam logic [4:0] MAX_PENDING = 5'(pvm_pkg::CMD_DEPTH + pvm_pkg::OUT_DEPTH);

	logic [4:0] pend_q;
	logic       mix_in;
	logic       res_out;

	assign mix_in  = push && !full && opcode == pvm_pkg::OP_MIX;
	assign res_out = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (mix_in && !res_out) begin
			pend_q <= pend_q + 1'b1;
		end else if (res_out && !mix_in) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != 5'd0)
		else $error("result shown with no mix beat outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= MAX_PENDING)
		else $error("more mix beats outstanding than the queues can hold");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("waiting result withdrawn");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(mix_left_out) && $stable(mix_right_out)
			&& $stable(voice_playing) && $stable(frame_position))
		else $error("waiting result changed");

endmodule

bind pcm_voice_mixer pvm_checker u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pcm_voice_mixer: directed and random beats checked
// against a voice model kept in this file. Depends on pvm_pkg and the RTL only.
module tb;
	import pvm_pkg::*;

	localparam int          HALF_PERIOD  = 2;
	localparam int          RESET_CYCLES = 7;
	localparam int          DRAIN_CYCLES = 16;
	localparam int          CYCLE_LIMIT  = 1000000;
	localparam logic [2:0]  OP_SPARE_LO  = 3'd6;
	localparam logic [2:0]  OP_SPARE_HI  = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [2:0]         opcode;
	logic [15:0]        write_address;
	logic signed [15:0] write_value;
	logic signed [15:0] mix_left_in;
	logic signed [15:0] mix_right_in;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [15:0] mix_left_out;
	logic signed [15:0] mix_right_out;
	logic               voice_playing;
	logic [15:0]        frame_position;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [16:0]        cfg_data;

	// Voice model state and its copy of the registers.
	logic [15:0] store_model [0:STORE_DEPTH-1];
	bit          written     [0:STORE_DEPTH-1];
	logic [15:0] pos_model     = 16'd0;
	logic        playing_model = 1'b0;
	logic [1:0]  cfg_channels  = 2'd2;
	logic [16:0] cfg_total     = 17'd0;
	logic        cfg_loop      = 1'b0;
	logic [15:0] cfg_volume    = VOLUME_ONE;

	res_t        mix_frames_due [$];
	int unsigned send_idle  = 0;
	int unsigned recv_idle  = 0;
	int unsigned mismatches = 0;
	int unsigned cycles     = 0;

	pcm_voice_mixer u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .opcode(opcode),
		.write_address(write_address), .write_value(write_value),
		.mix_left_in(mix_left_in), .mix_right_in(mix_right_in),
		.empty(empty), .pop(pop), .mix_left_out(mix_left_out),
		.mix_right_out(mix_right_out), .voice_playing(voice_playing),
		.frame_position(frame_position), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	function automatic logic [15:0] any16();
		return 16'($urandom);
	endfunction

	function automatic int unsigned live_channels();
		if (cfg_channels == 2'd0)
			return 1;
		if (cfg_channels > 2'd2)
			return 2;
		return cfg_channels;
	endfunction

	function automatic logic [15:0] next_position();
		longint unsigned t;
		t = longint'(pos_model) + live_channels();
		if (t >= cfg_total)
			t -= cfg_total;
		return t[15:0];
	endfunction

	// Index k of a frame: 0 left now, 1 right now, 2 left next, 3 right next.
	function automatic logic [15:0] read_index(input int k);
		logic [15:0] base;
		int unsigned c;
		c = live_channels();
		base = (k < 2) ? pos_model : next_position();
		if (c > 1)
			base[0] = 1'b0;
		if (k % 2 == 1)
			base = base + 16'(c - 1);
		return base;
	endfunction

	function automatic int voice_share(input logic [15:0] a, input logic [15:0] b,
			input int unsigned vol);
		int     sa;
		int     sb;
		int     avg;
		longint prod;
		sa = $signed(a);
		sb = $signed(b);
		avg = (sa + sb) / 2;
		prod = longint'(avg) * longint'(vol);
		if (prod < 0)
			return -int'((-prod) >> 15);
		return int'(prod >> 15);
	endfunction

	function automatic void advance_voice(input logic [2:0] op, input logic [15:0] addr,
			input logic [15:0] val, input logic signed [15:0] ml,
			input logic signed [15:0] mr);
		int          l;
		int          r;
		int unsigned c;
		int unsigned vol;
		longint      limit;
		logic [15:0] nxt;
		res_t        due;
		case (op)
			OP_WRITE: begin
				store_model[addr] = val;
				written[addr] = 1'b1;
			end
			OP_PLAY: playing_model = 1'b1;
			OP_PAUSE: playing_model = 1'b0;
			OP_RESTART: begin
				playing_model = 1'b1;
				pos_model = 16'd0;
			end
			OP_STOP: begin
				playing_model = 1'b0;
				pos_model = 16'd0;
			end
			OP_MIX: begin
				l = ml;
				r = mr;
				if (playing_model) begin
					c = live_channels();
					vol = (cfg_volume > VOLUME_ONE) ? VOLUME_ONE : cfg_volume;
					nxt = next_position();
					l += voice_share(store_model[read_index(0)],
						store_model[read_index(2)], vol);
					r += voice_share(store_model[read_index(1)],
						store_model[read_index(3)], vol);
					pos_model = nxt;
					limit = longint'(cfg_total) - longint'(c) - 1;
					if (longint'(pos_model) >= limit) begin
						pos_model = 16'd0;
						if (!cfg_loop)
							playing_model = 1'b0;
					end
				end
				due.left = l[15:0];
				due.right = r[15:0];
				due.playing = playing_model;
				due.position = pos_model;
				mix_frames_due.push_back(due);
			end
			default: ;
		endcase
	endfunction

	task automatic log_mismatch(input string msg);
		mismatches++;
		$display("ERROR cycle %0d: %s", cycles, msg);
	endtask

	task automatic check_frame();
		res_t want;
		if (mix_frames_due.size() == 0) begin
			log_mismatch("mix beat with nothing pending");
			return;
		end
		want = mix_frames_due.pop_front();
		if (mix_left_out !== want.left || mix_right_out !== want.right ||
				voice_playing !== want.playing || frame_position !== want.position)
			log_mismatch({
				$sformatf("got L=%0d R=%0d play=%0b pos=%0d, ",
					mix_left_out, mix_right_out, voice_playing, frame_position),
				$sformatf("want L=%0d R=%0d play=%0b pos=%0d",
					want.left, want.right, want.playing, want.position)});
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			check_frame();
		pop <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_beat(input logic [2:0] op, input logic [15:0] addr,
			input logic [15:0] val, input logic signed [15:0] ml,
			input logic signed [15:0] mr);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		write_address <= addr;
		write_value <= val;
		mix_left_in <= ml;
		mix_right_in <= mr;
		@(posedge clk);
		while (full)
			@(posedge clk);
		advance_voice(op, addr, val, ml, mr);
	endtask

	task automatic ctrl_beat(input logic [2:0] op);
		send_beat(op, any16(), any16(), any16(), any16());
	endtask

	// Every store entry that the coming frame reads is loaded first.
	task automatic mix_beat(input logic signed [15:0] ml, input logic signed [15:0] mr);
		logic [15:0] idx;
		if (playing_model) begin
			for (int k = 0; k < 4; k++) begin
				idx = read_index(k);
				if (!written[idx])
					send_beat(OP_WRITE, idx, any16(), any16(), any16());
			end
		end
		send_beat(OP_MIX, any16(), any16(), ml, mr);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (mix_frames_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [1:0] ch, input logic [16:0] tot, input logic lp,
			input logic [15:0] vol);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CHANNELS;
		cfg_data <= {15'd0, ch};
		@(posedge clk);
		cfg_index <= CFG_TOTAL;
		cfg_data <= tot;
		@(posedge clk);
		cfg_index <= CFG_LOOP;
		cfg_data <= {16'd0, lp};
		@(posedge clk);
		cfg_index <= CFG_VOLUME;
		cfg_data <= {1'b0, vol};
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_channels = ch;
		cfg_total = tot;
		cfg_loop = lp;
		cfg_volume = vol;
	endtask

	task automatic pick_config();
		logic [1:0]  ch;
		logic [16:0] tot;
		logic [15:0] vol;
		int unsigned roll;
		roll = $urandom_range(99);
		ch = (roll < 40) ? 2'd2 : (roll < 80) ? 2'd1 : 2'($urandom_range(3));
		roll = $urandom_range(99);
		tot = (roll < 70) ? 17'($urandom_range(40)) : (roll < 78) ? 17'd65536 :
			(roll < 84) ? 17'd65535 : (roll < 90) ? 17'($urandom_range(131071)) :
			17'($urandom_range(300));
		roll = $urandom_range(99);
		vol = (roll < 15) ? 16'd0 : (roll < 40) ? VOLUME_ONE : (roll < 50) ? 16'h7FFF :
			(roll < 60) ? 16'hFFFF : any16();
		configure(ch, tot, 1'($urandom_range(1)), vol);
	endtask

	task automatic test_directed();
		mix_beat(16'sh8000, 16'sh7FFF);
		send_beat(OP_WRITE, 16'd0, 16'h7FFF, 16'sd0, 16'sd0);
		send_beat(OP_WRITE, 16'd1, 16'h8000, 16'sd0, 16'sd0);
		send_beat(OP_WRITE, 16'd2, 16'h7FFF, 16'sd0, 16'sd0);
		send_beat(OP_WRITE, 16'd3, 16'h8000, 16'sd0, 16'sd0);
		send_beat(OP_WRITE, 16'hFFFF, 16'hFFFF, 16'sd0, 16'sd0);
		settle();
		configure(2'd2, 17'd8, 1'b0, VOLUME_ONE);
		ctrl_beat(OP_PLAY);
		mix_beat(16'sh7FFF, 16'sh8000);
		mix_beat(16'sh8000, 16'sh7FFF);
		mix_beat(any16(), any16());
		mix_beat(any16(), any16());
		ctrl_beat(OP_RESTART);
		mix_beat(any16(), any16());
		ctrl_beat(OP_PAUSE);
		mix_beat(any16(), any16());
		ctrl_beat(OP_STOP);
		send_beat(OP_SPARE_LO, any16(), any16(), any16(), any16());
		send_beat(OP_SPARE_HI, any16(), any16(), any16(), any16());
		mix_beat(any16(), any16());
		settle();
		configure(2'd0, 17'd5, 1'b1, 16'hFFFF);
		ctrl_beat(OP_RESTART);
		repeat (4) mix_beat(any16(), any16());
		settle();
		configure(2'd3, 17'd0, 1'b0, 16'd0);
		ctrl_beat(OP_RESTART);
		mix_beat(any16(), any16());
		settle();
		configure(2'd1, 17'd65536, 1'b1, 16'h7FFF);
		ctrl_beat(OP_PLAY);
		mix_beat(any16(), any16());
	endtask

	task automatic test_random(input int unsigned n_items);
		int unsigned done;
		int unsigned roll;
		done = 0;
		while (done < n_items) begin
			if (done % 90 == 0) begin
				settle();
				pick_config();
			end else if (done == n_items / 2) begin
				settle();
			end
			done++;
			if (!playing_model && $urandom_range(99) < 50) begin
				ctrl_beat($urandom_range(1) ? OP_PLAY : OP_RESTART);
				continue;
			end
			roll = $urandom_range(99);
			if (roll < 55)
				mix_beat(any16(), any16());
			else if (roll < 60)
				mix_beat(roll[0] ? 16'sh8000 : 16'sh7FFF, roll[0] ? 16'sh7FFF : 16'sh8000);
			else if (roll < 72)
				send_beat(OP_WRITE, 16'($urandom_range(70)), any16(), any16(), any16());
			else if (roll < 78)
				ctrl_beat(OP_PLAY);
			else if (roll < 83)
				ctrl_beat(OP_PAUSE);
			else if (roll < 88)
				ctrl_beat(OP_STOP);
			else if (roll < 94)
				ctrl_beat(OP_RESTART);
			else if (roll < 97) begin
				ctrl_beat(roll[0] ? OP_SPARE_LO : OP_SPARE_HI);
				done--;
			end else
				send_beat(OP_WRITE, any16(), any16(), any16(), any16());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		opcode <= OP_WRITE;
		write_address <= 16'd0;
		write_value <= 16'sd0;
		mix_left_in <= 16'sd0;
		mix_right_in <= 16'sd0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_CHANNELS;
		cfg_data <= 17'd0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		send_idle = 18;
		recv_idle = 88;
		test_random(450);
		send_idle = 88;
		recv_idle = 18;
		test_random(450);
		send_idle = 0;
		recv_idle = 0;
		test_random(450);

		push <= 1'b0;
		while (mix_frames_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && mix_frames_due.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule

// ===== files.f =====
src/pvm_pkg.sv
src/pvm_front.sv
src/pvm_cmd_queue.sv
src/pvm_back.sv
src/pcm_voice_mixer.sv
src/pvm_checker.sv
tb/tb.sv
